@@ sv/irc_pkg.sv @@
// Shared types and constants for the IPv4 ingress route classifier.
package irc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  PROTO_UDP    = 8'h11;
  localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;
  localparam logic [15:0] HEADER_BYTES = 16'd20;
  localparam logic [31:0] NET_MASK_24  = 32'hFFFF_FF00;
  localparam logic [1:0]  PORT_ONE     = 2'd1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_TWO = 1'b1;

  typedef enum logic [2:0] {
    V_OWN           = 3'd0,
    V_BAD_CSUM      = 3'd1,
    V_UDP           = 3'd2,
    V_FORWARD       = 3'd3,
    V_NO_ROUTE      = 3'd4,
    V_ENTRY_WRITTEN = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    K_OWN,
    K_BAD_CSUM,
    K_UDP,
    K_LOOKUP,
    K_WRITE
  } kind_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  arrival_port;
    logic [63:0] header_front;
    logic [63:0] header_middle;
    logic [31:0] header_back;
    logic [3:0]  entry_index;
    logic [31:0] entry_network;
    logic [31:0] entry_next_hop;
    logic        entry_valid;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] next_hop_address;
    logic [3:0]  matched_index;
    logic [15:0] udp_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] udp_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [3:0]  entry_index;
    logic [31:0] entry_network;
    logic [31:0] entry_next_hop;
    logic        entry_valid;
  } q_entry_t;

endpackage

@@ sv/irc_front.sv @@
// Front end: checks own address and header checksum and sorts each word by kind.
module irc_front
  import irc_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  input  logic [31:0]       port_one_addr,
  input  logic [31:0]       port_two_addr,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output q_entry_t          q_entry
);

  logic [19:0] csum_raw;
  logic [16:0] csum_f1;
  logic [16:0] csum_f2;
  logic        csum_ok;
  logic [31:0] own_addr;
  logic [31:0] src_addr;
  logic [15:0] total_len;
  logic [7:0]  proto;

  assign in_stall = (q_count == QCNT_W'(QUEUE_DEPTH));
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    csum_raw = 20'(in_data.header_front[63:48])  + 20'(in_data.header_front[47:32])
             + 20'(in_data.header_front[31:16])  + 20'(in_data.header_front[15:0])
             + 20'(in_data.header_middle[63:48]) + 20'(in_data.header_middle[47:32])
             + 20'(in_data.header_middle[31:16]) + 20'(in_data.header_middle[15:0])
             + 20'(in_data.header_back[31:16])   + 20'(in_data.header_back[15:0]);
    // fold carries back in twice
    csum_f1 = 17'(csum_raw[15:0]) + 17'(csum_raw[19:16]);
    csum_f2 = 17'(csum_f1[15:0]) + 17'(csum_f1[16]);
    csum_ok = (csum_f2 == {1'b0, CSUM_GOOD});
  end

  assign own_addr  = (in_data.arrival_port == PORT_ONE) ? port_one_addr : port_two_addr;
  assign src_addr  = in_data.header_middle[31:0];
  assign total_len = in_data.header_front[47:32];
  assign proto     = in_data.header_middle[55:48];

  always_comb begin
    q_entry.udp_length     = (total_len >= HEADER_BYTES) ? total_len - HEADER_BYTES : 16'd0;
    q_entry.source_address = src_addr;
    q_entry.dest_address   = in_data.header_back;
    q_entry.entry_index    = in_data.entry_index;
    q_entry.entry_network  = in_data.entry_network;
    q_entry.entry_next_hop = in_data.entry_next_hop;
    q_entry.entry_valid    = in_data.entry_valid;
    priority if (in_data.mode) begin
      q_entry.kind = K_WRITE;
    end else if (src_addr == own_addr) begin
      q_entry.kind = K_OWN;
    end else if (!csum_ok) begin
      q_entry.kind = K_BAD_CSUM;
    end else if (proto == PROTO_UDP) begin
      q_entry.kind = K_UDP;
    end else begin
      q_entry.kind = K_LOOKUP;
    end
  end

endmodule

@@ sv/irc_queue.sv @@
// Short FIFO of classified words between the front end and the back end.
module irc_queue
  import irc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  q_entry_t          push_entry,
  input  logic              pop,
  output logic              q_valid,
  output q_entry_t          q_head,
  output logic [QCNT_W-1:0] q_count
);

  q_entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign q_valid = (count_r != '0);
  assign q_head  = slot_r[rd_ptr_r];
  assign q_count = count_r;

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ sv/irc_back.sv @@
// Back end: route table, lookup and result register.
module irc_back
  import irc_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // slot index is four bits wide, so only the first sixteen slots are reachable
  localparam int TBL_N = (ROUTE_ENTRIES < 16) ? ROUTE_ENTRIES : 16;

  logic [31:0]      route_net_r [TBL_N];
  logic [31:0]      route_hop_r [TBL_N];
  logic [TBL_N-1:0] route_use_r;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  logic        hit;
  logic [3:0]  hit_index;
  logic [31:0] hit_hop;
  logic [31:0] dst_net;
  logic        tbl_write;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign tbl_write = q_pop && (q_head.kind == K_WRITE);
  assign dst_net   = q_head.dest_address & NET_MASK_24;

  // lowest matching slot wins
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    hit_hop   = '0;
    for (int i = 0; i < TBL_N; i++) begin
      if (!hit && route_use_r[i] && (route_net_r[i] == dst_net)) begin
        hit       = 1'b1;
        hit_index = 4'(i);
        hit_hop   = route_hop_r[i];
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    unique case (q_head.kind)
      K_OWN:      out_data_nxt.verdict = V_OWN;
      K_BAD_CSUM: out_data_nxt.verdict = V_BAD_CSUM;
      K_UDP: begin
        out_data_nxt.verdict        = V_UDP;
        out_data_nxt.udp_length     = q_head.udp_length;
        out_data_nxt.source_address = q_head.source_address;
        out_data_nxt.dest_address   = q_head.dest_address;
      end
      K_LOOKUP: begin
        if (hit) begin
          out_data_nxt.verdict          = V_FORWARD;
          out_data_nxt.next_hop_address = (hit_hop != '0) ? hit_hop : q_head.dest_address;
          out_data_nxt.matched_index    = hit_index;
        end else begin
          out_data_nxt.verdict = V_NO_ROUTE;
        end
      end
      K_WRITE:    out_data_nxt.verdict = V_ENTRY_WRITTEN;
      default:    out_data_nxt.verdict = V_NO_ROUTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_use_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < TBL_N; i++) begin
        if (tbl_write && (q_head.entry_index == 4'(i))) begin
          route_use_r[i] <= q_head.entry_valid;
        end
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TBL_N; i++) begin
      if (tbl_write && (q_head.entry_index == 4'(i))) begin
        route_net_r[i] <= q_head.entry_network;
        route_hop_r[i] <= q_head.entry_next_hop;
      end
    end
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/ipv4_ingress_route_classifier_unit.sv @@
// IPv4 ingress route classifier: top level with port address registers.
//
// Input channel (in_valid / in_stall / in_data): each word is either a 20-byte
// IPv4 header with its arrival port (mode 0) or a route table write (mode 1).
// Result channel (out_valid / out_stall / out_data): exactly one result word
// per input word, in input order, carrying the verdict and its fields.
// Configuration: cfg_we writes cfg_wdata into the port address picked by
// cfg_index; write only while no word is in flight.
// Words pass through the queue into the result register. One word per cycle
// is sustained while out_stall is low; the checksum adder tree sits
// in the front end before the queue, the parallel table compare in the back end.
// A two-entry queue separates the front and back ends, so the input is still
// taken while a finished result waits for the receiver.
// When out_stall is held, the result register holds, the queue fills, and then
// in_stall rises until the receiver takes the waiting word.
// Reset: port addresses go to zero, every route slot is marked unused, and the
// queue and result register are emptied; no clearing pass is needed.
module ipv4_ingress_route_classifier_unit
  import irc_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic [31:0]       port_one_addr_r;
  logic [31:0]       port_two_addr_r;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  q_entry_t          q_entry;
  q_entry_t          q_head;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_one_addr_r <= '0;
      port_two_addr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PORT_ONE: port_one_addr_r <= cfg_wdata;
        CFG_PORT_TWO: port_two_addr_r <= cfg_wdata;
        default:      port_two_addr_r <= port_two_addr_r;
      endcase
    end
  end

  irc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .port_one_addr (port_one_addr_r),
    .port_two_addr (port_two_addr_r),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  irc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_count    (q_count)
  );

  irc_back #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a pushed word is in the queue on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) q_push |=> q_valid)
    else $error("pushed word missing from queue");

  // stall only when the queue is full
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_count == QCNT_W'(QUEUE_DEPTH)))
    else $error("input stalled with room in queue");

  // non-forward results carry no next hop or slot
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.verdict != V_FORWARD)) |->
    ((out_data.next_hop_address == '0) && (out_data.matched_index == '0)))
    else $error("next hop set on non-forward result");

  // only udp results carry length and addresses
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.verdict != V_UDP)) |->
    ((out_data.udp_length == '0) && (out_data.source_address == '0)
     && (out_data.dest_address == '0)))
    else $error("udp fields set on non-udp result");

endmodule

@@ test/irc_tb_pkg.sv @@
// Verdict scoreboard for the IPv4 ingress route classifier testbench.
package irc_tb_pkg;
  import irc_pkg::*;

  localparam int ROUTE_SLOTS = 16;
  localparam int MAX_REPORTS = 10;

  // Ones'-complement sum of the ten header halfwords, carries folded back in.
  function automatic logic [15:0] header_ones_sum(logic [63:0] front, logic [63:0] middle,
                                                  logic [31:0] back);
    int unsigned s;
    s = back[15:0] + back[31:16];
    for (int k = 0; k < 4; k++) begin
      s += front[16*k +: 16];
      s += middle[16*k +: 16];
    end
    s = (s & 32'hFFFF) + (s >> 16);
    s = (s & 32'hFFFF) + (s >> 16);
    return s[15:0];
  endfunction

  class verdict_board;
    logic [31:0] port_one_addr;
    logic [31:0] port_two_addr;
    logic [31:0] route_net [ROUTE_SLOTS];
    logic [31:0] route_hop [ROUTE_SLOTS];
    bit          route_used [ROUTE_SLOTS];
    out_item_t   pending_verdicts [$];
    int unsigned mismatches;

    function new();
      port_one_addr = '0;
      port_two_addr = '0;
      mismatches    = 0;
      foreach (route_net[i]) begin
        route_net[i]  = '0;
        route_hop[i]  = '0;
        route_used[i] = 1'b0;
      end
    endfunction

    function void set_port_address(logic [CFG_IDX_W-1:0] idx, logic [31:0] addr);
      if (idx == CFG_PORT_ONE) port_one_addr = addr;
      else port_two_addr = addr;
    endfunction

    function out_item_t predict_verdict(in_item_t w);
      out_item_t   r;
      logic [31:0] own;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] net;
      logic [15:0] total;
      r = '0;
      if (w.mode) begin
        if (int'(w.entry_index) < ROUTE_SLOTS) begin
          route_net[w.entry_index]  = w.entry_network;
          route_hop[w.entry_index]  = w.entry_next_hop;
          route_used[w.entry_index] = w.entry_valid;
        end
        r.verdict = V_ENTRY_WRITTEN;
        return r;
      end
      src   = w.header_middle[31:0];
      dst   = w.header_back;
      total = w.header_front[47:32];
      // ports 0, 2 and 3 all check against the port two address
      own   = (w.arrival_port == PORT_ONE) ? port_one_addr : port_two_addr;
      if (src == own) begin
        r.verdict = V_OWN;
      end else if (header_ones_sum(w.header_front, w.header_middle, w.header_back)
                   != CSUM_GOOD) begin
        r.verdict = V_BAD_CSUM;
      end else if (w.header_middle[55:48] == PROTO_UDP) begin
        r.verdict        = V_UDP;
        r.udp_length     = (total >= HEADER_BYTES) ? total - HEADER_BYTES : 16'd0;
        r.source_address = src;
        r.dest_address   = dst;
      end else begin
        net       = dst & NET_MASK_24;
        r.verdict = V_NO_ROUTE;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (route_used[i] && route_net[i] == net) begin
            r.verdict          = V_FORWARD;
            r.next_hop_address = (route_hop[i] != 0) ? route_hop[i] : dst;
            r.matched_index    = 4'(i);
            break;
          end
        end
      end
      return r;
    endfunction

    function void note_input(in_item_t w);
      pending_verdicts.push_back(predict_verdict(w));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: verdict %0d", got.verdict);
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict || got.next_hop_address !== want.next_hop_address ||
          got.matched_index !== want.matched_index || got.udp_length !== want.udp_length ||
          got.source_address !== want.source_address ||
          got.dest_address !== want.dest_address) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected verdict %0d hop %h idx %0d len %0d src %h dst %h",
                   want.verdict, want.next_hop_address, want.matched_index,
                   want.udp_length, want.source_address, want.dest_address);
          $display("          actual   verdict %0d hop %h idx %0d len %0d src %h dst %h",
                   got.verdict, got.next_hop_address, got.matched_index,
                   got.udp_length, got.source_address, got.dest_address);
        end
      end
    endfunction

    function void close_out();
      if (pending_verdicts.size() != 0) begin
        mismatches += pending_verdicts.size();
        $display("%0d expected results never arrived", pending_verdicts.size());
      end
    endfunction
  endclass

endpackage

@@ test/tb_ipv4_ingress_route_classifier_unit.sv @@
// Testbench top for the IPv4 ingress route classifier unit.
module tb_ipv4_ingress_route_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import irc_pkg::*;
  import irc_tb_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASE_WORDS   = 166;
  localparam int PHASES        = 5;
  localparam int IN_W          = $bits(in_item_t);

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  verdict_board board = new();
  bit           idle_on;
  int           stall_left = 0;
  int           quiet_cycles = 0;
  logic [31:0]  net_pool [8];

  ipv4_ingress_route_classifier_unit #(.ROUTE_ENTRIES(ROUTE_SLOTS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Header with a correct checksum; corrupt flips one checksum bit.
  function automatic in_item_t build_header(logic [1:0] port, logic [15:0] total,
                                            logic [7:0] proto, logic [31:0] src,
                                            logic [31:0] dst, bit corrupt);
    in_item_t w;
    w.mode                = 1'b0;
    w.arrival_port        = port;
    w.header_front        = {$urandom(), $urandom()};
    w.header_front[47:32] = total;
    w.header_middle       = {$urandom(), $urandom()};
    w.header_middle[55:48] = proto;
    w.header_middle[47:32] = 16'h0000;
    w.header_middle[31:0]  = src;
    w.header_back         = dst;
    w.entry_index         = 4'($urandom());
    w.entry_network       = $urandom();
    w.entry_next_hop      = $urandom();
    w.entry_valid         = 1'($urandom());
    w.header_middle[47:32] = ~header_ones_sum(w.header_front, w.header_middle, w.header_back);
    if (corrupt) w.header_middle[32 + $urandom_range(0, 15)] ^= 1'b1;
    return w;
  endfunction

  function automatic in_item_t build_route(logic [3:0] slot, logic [31:0] net,
                                           logic [31:0] hop, logic on);
    in_item_t w;
    w                = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom()});
    w.mode           = 1'b1;
    w.entry_index    = slot;
    w.entry_network  = net;
    w.entry_next_hop = hop;
    w.entry_valid    = on;
    return w;
  endfunction

  function automatic in_item_t random_word();
    in_item_t    w;
    int unsigned pick;
    logic [1:0]  port;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] total;
    logic [7:0]  proto;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return build_route(4'($urandom()),
                         ($urandom_range(0, 4) != 0) ? net_pool[$urandom_range(0, 7)]
                                                     : 32'($urandom()),
                         ($urandom_range(0, 2) == 0) ? 32'h0 : 32'($urandom()),
                         ($urandom_range(0, 6) != 0));
    end
    if (pick < 25) begin
      // raw noise, mostly with a broken checksum
      w = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom()});
      return w;
    end
    port  = ($urandom_range(0, 4) == 0) ? 2'($urandom()) : 2'($urandom_range(1, 2));
    src   = $urandom();
    if ($urandom_range(0, 9) == 0)
      src = (port == PORT_ONE) ? board.port_one_addr : board.port_two_addr;
    proto = ($urandom_range(0, 99) < 35) ? PROTO_UDP : 8'($urandom());
    total = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 25)) : 16'($urandom());
    dst   = ($urandom_range(0, 3) != 0) ? (net_pool[$urandom_range(0, 7)] | 8'($urandom()))
                                        : 32'($urandom());
    return build_header(port, total, proto, src, dst, $urandom_range(0, 9) == 0);
  endfunction

  task automatic send_word(input in_item_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(w);
  endtask

  // Hold the input until every expected result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_port_addresses(input logic [31:0] one, input logic [31:0] two);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PORT_ONE;
    cfg_wdata <= one;
    @(posedge clk);
    cfg_index <= CFG_PORT_TWO;
    cfg_wdata <= two;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    board.set_port_address(CFG_PORT_ONE, one);
    board.set_port_address(CFG_PORT_TWO, two);
  endtask

  task automatic run_directed();
    in_item_t w;
    send_word(build_header(2'd1, 16'd40, 8'd6, 32'h0101_0101, 32'h0A01_0205, 1'b0));
    // own address on each port value
    send_word(build_header(2'd1, 16'd40, 8'd6, 32'h0A00_0001, 32'h0A01_0205, 1'b0));
    send_word(build_header(2'd2, 16'd40, 8'd6, 32'hC0A8_0101, 32'h0A01_0205, 1'b0));
    send_word(build_header(2'd0, 16'd40, 8'd6, 32'hC0A8_0101, 32'h0A01_0205, 1'b0));
    send_word(build_header(2'd3, 16'd40, 8'd6, 32'hC0A8_0101, 32'h0A01_0205, 1'b0));
    send_word(build_header(2'd1, 16'd40, 8'd6, 32'hC0A8_0101, 32'h0A01_0205, 1'b0));
    // own test wins over a bad checksum
    send_word(build_header(2'd1, 16'd40, 8'd6, 32'h0A00_0001, 32'h0A01_0205, 1'b1));
    send_word(build_header(2'd1, 16'd40, 8'd6, 32'h0505_0505, 32'h0A01_0205, 1'b1));
    send_word(build_header(2'd1, 16'd28, PROTO_UDP, 32'h0505_0505, 32'h0606_0606, 1'b0));
    send_word(build_header(2'd1, 16'd0, PROTO_UDP, 32'h0505_0505, 32'h0606_0606, 1'b0));
    send_word(build_header(2'd2, 16'd19, PROTO_UDP, 32'h0505_0505, 32'h0606_0606, 1'b0));
    send_word(build_header(2'd2, 16'd20, PROTO_UDP, 32'h0505_0505, 32'h0606_0606, 1'b0));
    send_word(build_header(2'd2, 16'hFFFF, PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 1'b0));
    send_word(build_header(2'd1, 16'd28, PROTO_UDP, 32'h0505_0505, 32'h0606_0606, 1'b1));
    // lowest slot wins, then falls through to the next one once removed
    send_word(build_route(4'd0, 32'h0A01_0200, 32'h0, 1'b1));
    send_word(build_route(4'd15, 32'h0A01_0200, 32'h0B0B_0B0B, 1'b1));
    send_word(build_header(2'd1, 16'd60, 8'd1, 32'h0505_0505, 32'h0A01_02FF, 1'b0));
    send_word(build_route(4'd0, 32'h0A01_0200, 32'h0, 1'b0));
    send_word(build_header(2'd1, 16'd60, 8'd1, 32'h0505_0505, 32'h0A01_02FF, 1'b0));
    // stored network with host bits never matches
    send_word(build_route(4'd7, 32'h0A01_0301, 32'h1, 1'b1));
    send_word(build_header(2'd2, 16'd60, 8'd1, 32'h0505_0505, 32'h0A01_0301, 1'b0));
    send_word(build_route(4'd3, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1));
    w = '1;
    w.mode = 1'b0;
    send_word(w);
    send_word(build_header(2'd1, 16'd0, 8'd0, 32'h0, 32'h0, 1'b0));
  endtask

  // Result side: check, then stall in random bursts while idle_on is set.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_PORT_ONE;
    cfg_wdata    <= '0;
    idle_on      = 1'b1;
    net_pool[0] = 32'h0;
    net_pool[7] = 32'hFFFF_FF00;
    for (int i = 1; i < 7; i++) net_pool[i] = $urandom() & NET_MASK_24;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_port_addresses(32'h0A00_0001, 32'hC0A8_0101);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain_results();
        case (p)
          1: load_port_addresses(32'h0, 32'h0);
          2: load_port_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
          3: load_port_addresses($urandom(), $urandom());
          default: load_port_addresses(32'hFFFF_FFFF, 32'h0);
        endcase
      end
      // last phase runs at full rate on both sides
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
    end
    drain_results();
    repeat (10) @(posedge clk);
    board.close_out();
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/irc_pkg.sv
sv/irc_front.sv
sv/irc_queue.sv
sv/irc_back.sv
sv/ipv4_ingress_route_classifier_unit.sv
test/irc_tb_pkg.sv
test/tb_ipv4_ingress_route_classifier_unit.sv
